// ===== src/gray_pixel_quantize_pack_top_defines.svh =====
// Assertion helpers used by the top-level RTL.
`ifndef GRAY_PIXEL_QUANTIZE_PACK_TOP_DEFINES_SVH
`define GRAY_PIXEL_QUANTIZE_PACK_TOP_DEFINES_SVH

// Same-cycle implication.
`define GPQP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GPQP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/gpqp_pkg.sv =====
package gpqp_pkg;

  localparam int LANES             = 8;
  localparam int SAMPLE_W          = 16;
  localparam int DIM_W             = 13;
  localparam int CNT_W             = 12;
  localparam int LEVEL_W           = 4;
  localparam int PROD_W            = 20;
  localparam int MAX_LEVELS        = 15;
  localparam int GRAY4_LEVELS      = 3;
  localparam int BYTE_W            = 8;
  localparam int MAX_DIMENSION_DEF = 4096;
  localparam int MIN_DIM           = 160;
  localparam int WIDTH_ALIGN       = 16;
  localparam int CFG_ADDR_W        = 2;
  localparam int CFG_DATA_W        = 16;

  localparam logic [SAMPLE_W-1:0] BLACK_SAMPLE = '0;

  localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_MAX = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SIXTEEN    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH      = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT     = 2'd3;

  localparam logic [SAMPLE_W-1:0] RST_SAMPLE_MAX = 16'd255;
  localparam logic [DIM_W-1:0]    RST_WIDTH      = 13'd160;
  localparam logic [DIM_W-1:0]    RST_HEIGHT     = 13'd160;

  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_GRAY4  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GRAY16 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MONO   = 2'd2;

  typedef logic [MAX_LEVELS:1][PROD_W-1:0]  thr_t;
  typedef logic [LANES-1:0][SAMPLE_W-1:0]   sample_vec_t;
  typedef logic [LANES-1:0][LEVEL_W-1:0]    level_vec_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_max;
    logic                zero_max;
    logic [MODE_W-1:0]   mode;
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic [DIM_W:0]      pad_width;
    logic [DIM_W-1:0]    pad_height;
    logic [DIM_W:0]      bytes_per_row;
  } cfg_state_t;

endpackage

// ===== src/gpqp_if.sv =====
interface gpqp_sample_if import gpqp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_0;
  logic [SAMPLE_W-1:0] sample_1;
  logic [SAMPLE_W-1:0] sample_2;
  logic [SAMPLE_W-1:0] sample_3;
  logic [SAMPLE_W-1:0] sample_4;
  logic [SAMPLE_W-1:0] sample_5;
  logic [SAMPLE_W-1:0] sample_6;
  logic [SAMPLE_W-1:0] sample_7;

  modport source (output valid, sample_0, sample_1, sample_2, sample_3,
                  sample_4, sample_5, sample_6, sample_7, input ready);
  modport sink (input valid, sample_0, sample_1, sample_2, sample_3,
                sample_4, sample_5, sample_6, sample_7, output ready);
endinterface

interface gpqp_result_if import gpqp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] packed_byte;
  logic              row_end;
  logic              image_end;
  logic [DIM_W-1:0]  padded_width;
  logic [DIM_W-1:0]  padded_height;

  modport source (output valid, packed_byte, row_end, image_end, padded_width,
                  padded_height, input ready);
  modport sink (input valid, packed_byte, row_end, image_end, padded_width,
                padded_height, output ready);
endinterface

interface gpqp_cfg_if import gpqp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// ===== src/gpqp_cfg.sv =====
module gpqp_cfg import gpqp_pkg::*; #(
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
  input  logic       clk,
  input  logic       rst,
  gpqp_cfg_if.sink   cfg,
  output cfg_state_t state,
  output thr_t       thr
);

  logic [SAMPLE_W-1:0] sample_max;
  logic                sixteen_level;
  logic [DIM_W-1:0]    image_width;
  logic [DIM_W-1:0]    image_height;
  logic [DIM_W-1:0]    w_cl;
  logic [DIM_W-1:0]    h_cl;
  logic [DIM_W:0]      w_round;
  logic [DIM_W:0]      pw;
  logic [MODE_W-1:0]   mode;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_max    <= RST_SAMPLE_MAX;
      sixteen_level <= 1'b0;
      image_width   <= RST_WIDTH;
      image_height  <= RST_HEIGHT;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.addr)
        REG_SAMPLE_MAX: sample_max    <= cfg.data;
        REG_SIXTEEN:    sixteen_level <= cfg.data[0];
        REG_WIDTH:      image_width   <= cfg.data[DIM_W-1:0];
        REG_HEIGHT:     image_height  <= cfg.data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // k * sample_max, registered in the cycle after the register changes
  always_ff @(posedge clk) begin
    for (int k = 1; k <= MAX_LEVELS; k++) begin
      thr[k] <= PROD_W'(sample_max) * PROD_W'(k);
    end
  end

  always_comb begin
    w_cl = (int'(image_width) > MAX_DIMENSION) ? DIM_W'(MAX_DIMENSION) : image_width;
    h_cl = (int'(image_height) > MAX_DIMENSION) ? DIM_W'(MAX_DIMENSION) : image_height;
    w_round = ({1'b0, w_cl} + (DIM_W+1)'(WIDTH_ALIGN - 1)) & ~(DIM_W+1)'(WIDTH_ALIGN - 1);
    pw = (w_round < (DIM_W+1)'(MIN_DIM)) ? (DIM_W+1)'(MIN_DIM) : w_round;
    if (sample_max == SAMPLE_W'(1)) begin
      mode = MODE_MONO;
    end else if (sixteen_level) begin
      mode = MODE_GRAY16;
    end else begin
      mode = MODE_GRAY4;
    end
    state.sample_max = sample_max;
    state.zero_max   = (sample_max == '0);
    state.mode       = mode;
    state.width      = w_cl;
    state.height     = h_cl;
    state.pad_width  = pw;
    state.pad_height = (h_cl < DIM_W'(MIN_DIM)) ? DIM_W'(MIN_DIM) : h_cl;
    case (mode)
      MODE_MONO:   state.bytes_per_row = pw >> 3;
      MODE_GRAY16: state.bytes_per_row = pw >> 1;
      default:     state.bytes_per_row = pw >> 2;
    endcase
  end

endmodule

// ===== src/gpqp_lane.sv =====
module gpqp_lane import gpqp_pkg::*; (
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [MODE_W-1:0]   mode,
  input  logic                zero_max,
  input  logic                on,
  input  thr_t                thr,
  output logic [LEVEL_W-1:0]  level
);

  logic [PROD_W-1:0]  prod;
  logic [LEVEL_W-1:0] max_level;
  logic [LEVEL_W-1:0] quot;

  always_comb begin
    if (mode == MODE_GRAY16) begin
      prod      = PROD_W'({sample, 4'b0}) - PROD_W'(sample);
      max_level = LEVEL_W'(MAX_LEVELS);
    end else begin
      prod      = PROD_W'({sample, 1'b0}) + PROD_W'(sample);
      max_level = LEVEL_W'(GRAY4_LEVELS);
    end
    // thresholds are monotone: largest k with k*max <= prod is the quotient
    quot = '0;
    for (int k = 1; k <= MAX_LEVELS; k++) begin
      if (LEVEL_W'(k) <= max_level && thr[k] <= prod) begin
        quot = LEVEL_W'(k);
      end
    end
    if (!on) begin
      level = '0;
    end else if (mode == MODE_MONO) begin
      level = (sample == BLACK_SAMPLE) ? LEVEL_W'(1) : '0;
    end else if (zero_max) begin
      level = max_level;
    end else begin
      level = max_level - quot;
    end
  end

endmodule

// ===== src/gpqp_merge.sv =====
module gpqp_merge import gpqp_pkg::*; (
  input  level_vec_t        levels,
  input  logic [MODE_W-1:0] mode,
  output logic [BYTE_W-1:0] byte_out
);

  always_comb begin
    byte_out = '0;
    case (mode)
      MODE_MONO: begin
        for (int i = 0; i < LANES; i++) begin
          byte_out[BYTE_W-1-i] = levels[i][0];
        end
      end
      MODE_GRAY16: begin
        for (int i = 0; i < 2; i++) begin
          byte_out[BYTE_W-1-4*i -: 4] = levels[i];
        end
      end
      default: begin
        for (int i = 0; i < 4; i++) begin
          byte_out[BYTE_W-1-2*i -: 2] = levels[i][1:0];
        end
      end
    endcase
  end

endmodule

// ===== src/gray_pixel_quantize_pack_top.sv =====
// The result passes the stage-one and output registers before it is offered.
// Throughput: one request per cycle unless stalled; an empty stage one fills in a stall.
// Quantization: in gray modes eight lanes test against registered k*sample_max thresholds.
// Reset: registers return to 255/0/160/160, column and row counters to 0, pipeline empties.
// Thresholds follow a sample_max write in the cycle after the register changes.
`include "gray_pixel_quantize_pack_top_defines.svh"

module gray_pixel_quantize_pack_top import gpqp_pkg::*; #(
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
  input  logic         clk,
  input  logic         rst,
  gpqp_sample_if.sink  samples,
  gpqp_result_if.source result,
  gpqp_cfg_if.sink     cfg
);

  cfg_state_t cs;
  thr_t       thr;

  logic [CNT_W-1:0] byte_column;
  logic [CNT_W-1:0] row_index;

  logic en1;
  logic en2;
  logic accept;

  sample_vec_t       raw;
  sample_vec_t       clamped;
  logic [LANES-1:0]  lane_on;
  logic [CNT_W+2:0]  col_base;
  logic              last_col;
  logic              last_row;

  logic              s1_v;
  sample_vec_t       s1_samples;
  logic [LANES-1:0]  s1_on;
  logic [MODE_W-1:0] s1_mode;
  logic              s1_zero;
  logic              s1_row_end;
  logic              s1_img_end;
  logic [DIM_W-1:0]  s1_pw;
  logic [DIM_W-1:0]  s1_ph;

  level_vec_t        levels;
  logic [BYTE_W-1:0] merged;

  logic              out_v;
  logic [BYTE_W-1:0] out_byte;
  logic              out_row_end;
  logic              out_img_end;
  logic [DIM_W-1:0]  out_pw;
  logic [DIM_W-1:0]  out_ph;

  gpqp_cfg #(.MAX_DIMENSION(MAX_DIMENSION)) u_cfg (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .state (cs),
    .thr   (thr)
  );

  assign en2           = !out_v || result.ready;
  assign en1           = !s1_v || en2;
  assign samples.ready = en1;
  assign accept        = samples.valid && en1;

  assign raw[0] = samples.sample_0;
  assign raw[1] = samples.sample_1;
  assign raw[2] = samples.sample_2;
  assign raw[3] = samples.sample_3;
  assign raw[4] = samples.sample_4;
  assign raw[5] = samples.sample_5;
  assign raw[6] = samples.sample_6;
  assign raw[7] = samples.sample_7;

  always_comb begin
    case (cs.mode)
      MODE_MONO:   col_base = {byte_column, 3'b000};
      MODE_GRAY16: col_base = {2'b00, byte_column, 1'b0};
      default:     col_base = {1'b0, byte_column, 2'b00};
    endcase
    for (int i = 0; i < LANES; i++) begin
      clamped[i] = (raw[i] > cs.sample_max) ? cs.sample_max : raw[i];
      lane_on[i] = ((col_base + (CNT_W+3)'(i)) < (CNT_W+3)'(cs.width))
                   && ({1'b0, row_index} < cs.height);
    end
    last_col = ((DIM_W+1)'(byte_column) + (DIM_W+1)'(1)) >= cs.bytes_per_row;
    last_row = (DIM_W'(row_index) + DIM_W'(1)) >= cs.pad_height;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_column <= '0;
      row_index   <= '0;
    end else if (accept) begin
      if (last_col) begin
        byte_column <= '0;
        row_index   <= last_row ? '0 : row_index + CNT_W'(1);
      end else begin
        byte_column <= byte_column + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en1) begin
      s1_v <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_samples <= clamped;
      s1_on      <= lane_on;
      s1_mode    <= cs.mode;
      s1_zero    <= cs.zero_max;
      s1_row_end <= last_col;
      s1_img_end <= last_col && last_row;
      s1_pw      <= cs.pad_width[DIM_W-1:0];
      s1_ph      <= cs.pad_height;
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    gpqp_lane u_lane (
      .sample   (s1_samples[g]),
      .mode     (s1_mode),
      .zero_max (s1_zero),
      .on       (s1_on[g]),
      .thr      (thr),
      .level    (levels[g])
    );
  end

  gpqp_merge u_merge (
    .levels   (levels),
    .mode     (s1_mode),
    .byte_out (merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en2) begin
      out_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_v) begin
      out_byte    <= merged;
      out_row_end <= s1_row_end;
      out_img_end <= s1_img_end;
      out_pw      <= s1_pw;
      out_ph      <= s1_ph;
    end
  end

  assign result.valid         = out_v;
  assign result.packed_byte   = out_byte;
  assign result.row_end       = out_row_end;
  assign result.image_end     = out_img_end;
  assign result.padded_width  = out_pw;
  assign result.padded_height = out_ph;

  `GPQP_ASSERT_SAME(a_img_end_row_end, clk, rst, out_v && out_img_end, out_row_end,
                    "image end without row end")
  `GPQP_ASSERT_NEXT(a_wrap, clk, rst, accept && last_col && last_row,
                    byte_column == '0 && row_index == '0, "counters did not wrap at image end")
  `GPQP_ASSERT_NEXT(a_s1_hold, clk, rst, s1_v && !en2,
                    s1_v && $stable(s1_samples) && $stable(s1_on), "stage one lost a stalled request")
  `GPQP_ASSERT_NEXT(a_thr_track, clk, rst, 1'b1, thr[1] == $past(PROD_W'(cs.sample_max)),
                    "threshold out of step with sample_max")

endmodule
